### rtl/dmx_pkg.sv
// dmx_pkg: types and constants shared by the dmx512 slot receiver
// used by dmx_slot_fsm and dmx512_slot_receiver, no dependencies
`default_nettype none

package dmx_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 16;
    localparam int unsigned M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_COUNT = 2'd2,
        PH_CAPT  = 2'd3
    } t_rx_phase;

    typedef struct packed {
        logic                slot_valid;
        logic [IDX_W-1:0]    slot_index;
        logic [BYTE_W-1:0]   slot_value;
        logic                frame_start;
        logic                last_slot;
    } t_result;

endpackage

`default_nettype wire

### rtl/dmx512_slot_receiver.sv
// dmx512_slot_receiver: top level, uart byte stream in, captured slot stream out
// depends on dmx_pkg and dmx_slot_fsm
//
// usage:
//   slave side takes one uart byte per beat: tdata = data byte, tuser = framing
//   error (a break). master side gives exactly one result beat per input beat.
//   the user writes start_address (reset value 1) only while idle; the block
//   does not enforce it.
// throughput: one byte per cycle while o_s_tready is high; the break/count
//   state machine updates on acceptance; the result goes to an output register.
// stall: when the sink holds tready low, one more result is caught in a skid
//   register; o_s_tready then drops until the skid register drains.
// reset: synchronous, active low; state returns to idle with a zero slot
//   counter, both output registers empty, start_address back to 1.
`default_nettype none

module dmx512_slot_receiver #(
    parameter int unsigned NUM_CHANNELS = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [dmx_pkg::CNT_W-1:0]      i_cfg_wr_data,
    // slave side
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [dmx_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic                           i_s_tuser,   // [0] framing_error
    // master side
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [dmx_pkg::M_TDATA_W-1:0]       o_m_tdata,   // [1:0] slot_index, [9:2] slot_value
    output logic [dmx_pkg::M_TUSER_W-1:0]       o_m_tuser,   // [0] slot_valid, [1] frame_start
    output logic                                o_m_tlast    // last_slot
);
    import dmx_pkg::*;

    logic [CNT_W-1:0] r_start_address;
    logic             beat;
    t_result          res;
    t_result          r_out, r_skid;
    logic             r_out_v, r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_start_address <= i_cfg_wr_data;
        end
    end

    assign o_s_tready = !r_skid_v;
    assign beat       = i_s_tvalid && o_s_tready;

    dmx_slot_fsm #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat          (beat),
        .i_data_byte     (i_s_tdata[BYTE_W-1:0]),
        .i_framing_error (i_s_tuser),
        .i_start_address (r_start_address),
        .o_result        (res)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= beat;
            end
        end else if (beat) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (beat) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {(M_TDATA_W-IDX_W-BYTE_W)'(0), r_out.slot_value, r_out.slot_index};
    assign o_m_tuser  = {r_out.frame_start, r_out.slot_valid};
    assign o_m_tlast  = r_out.last_slot;

endmodule

`default_nettype wire

### rtl/dmx_slot_fsm.sv
// dmx_slot_fsm: break / start code / slot count state machine
// gives the result of the current beat combinationally, updates state on accept
// depends on dmx_pkg
`default_nettype none

module dmx_slot_fsm #(
    parameter int unsigned NUM_CHANNELS = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_beat,
    input  wire logic [dmx_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_framing_error,
    input  wire logic [dmx_pkg::CNT_W-1:0]     i_start_address,
    output dmx_pkg::t_result                   o_result
);
    import dmx_pkg::*;

    localparam logic [CNT_W-1:0] NUM_CH = CNT_W'(NUM_CHANNELS);
    localparam logic             SINGLE = (NUM_CHANNELS <= 1);

    t_rx_phase        r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] cnt_dec, cnt_inc;
    t_result          res;

    assign cnt_dec = r_cnt - CNT_W'(1);
    assign cnt_inc = r_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_beat) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        res     = '0;
        if (i_framing_error) begin
            n_cnt   = i_start_address;
            n_phase = PH_BREAK;
        end else begin
            case (r_phase)
                PH_BREAK: begin
                    if (i_data_byte == '0) begin
                        n_phase         = PH_COUNT;
                        res.frame_start = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_COUNT: begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        res.slot_valid = 1'b1;
                        res.slot_value = i_data_byte;
                        res.last_slot  = SINGLE;
                        n_cnt          = CNT_W'(1);
                        n_phase        = SINGLE ? PH_IDLE : PH_CAPT;
                    end
                end
                PH_CAPT: begin
                    if (r_cnt < NUM_CH) begin
                        res.slot_valid = 1'b1;
                        res.slot_index = r_cnt[IDX_W-1:0];
                        res.slot_value = i_data_byte;
                        n_cnt          = cnt_inc;
                        if (cnt_inc >= NUM_CH) begin
                            res.last_slot = 1'b1;
                            n_phase       = PH_IDLE;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

### rtl/dmx_checker.sv
// dmx_checker: port-level checks on the dmx512 slot receiver, bound to the top
// depends on dmx_pkg and dmx512_slot_receiver
`default_nettype none

module dmx_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [dmx_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  wire logic [dmx_pkg::M_TUSER_W-1:0]  o_m_tuser,
    input  wire logic                           o_m_tlast
);

    // last slot only on a captured slot
    a_last_is_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("last flag without captured slot");

    // a start code beat never carries a slot
    a_start_not_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("frame start and slot on one beat");

    // beats without a slot carry zero data
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("non-slot beat with data");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled beat changed");

    // nothing on the output straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind dmx512_slot_receiver dmx_checker u_dmx_checker (.*);

`default_nettype wire

### test/dmx512_slot_receiver_tb.sv
// dmx512_slot_receiver_tb: self-checking bench for the dmx512 slot receiver, driving
// break/start-code/slot byte streams and checking every result beat against a predictor
// depends on dmx_pkg and dmx512_slot_receiver
`default_nettype none

module dmx512_slot_receiver_tb;
    import dmx_pkg::*;

    localparam int unsigned SLOTS = 3;
    localparam int unsigned BYTES_TARGET = 1800;
    localparam logic [8:0] BREAK_FLAG = 9'h100;
    localparam logic [8:0] DIRECTED_BEATS [22] = '{
        9'h055, BREAK_FLAG | 9'h0FF, 9'h000, 9'h000, 9'h0FF, 9'h0A5, 9'h012,
        BREAK_FLAG, 9'h001, 9'h000,
        BREAK_FLAG | 9'h0AA, 9'h000, 9'h07E, BREAK_FLAG | 9'h055, 9'h080,
        BREAK_FLAG, BREAK_FLAG, 9'h000, 9'h001, 9'h002, 9'h0FF, 9'h080
    };

    class slot_scoreboard;
        t_rx_phase        phase;
        logic [CNT_W-1:0] slot_cnt;
        logic [CNT_W-1:0] start_addr;
        t_result          pending_q[$];
        int               errors;
        int               starts;
        int               captures;
        int               frames_done;

        function new();
            phase       = PH_IDLE;
            slot_cnt    = '0;
            start_addr  = 10'd1;
            errors      = 0;
            starts      = 0;
            captures    = 0;
            frames_done = 0;
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] data, input logic brk);
            t_result want;
            want = '0;
            if (brk) begin
                slot_cnt = start_addr;
                phase    = PH_BREAK;
            end else begin
                case (phase)
                    PH_BREAK: begin
                        if (data == 8'h00) begin
                            phase = PH_COUNT;
                            want.frame_start = 1'b1;
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                    PH_COUNT: begin
                        slot_cnt = slot_cnt - 1'b1;
                        if (slot_cnt == '0) begin
                            want.slot_valid = 1'b1;
                            want.slot_index = '0;
                            want.slot_value = data;
                            slot_cnt = 10'd1;
                            if (SLOTS <= 1) begin
                                want.last_slot = 1'b1;
                                phase = PH_IDLE;
                            end else begin
                                phase = PH_CAPT;
                            end
                        end
                    end
                    PH_CAPT: begin
                        if (slot_cnt < SLOTS) begin
                            want.slot_valid = 1'b1;
                            want.slot_index = slot_cnt[IDX_W-1:0];
                            want.slot_value = data;
                            slot_cnt = slot_cnt + 1'b1;
                            if (slot_cnt >= SLOTS) begin
                                want.last_slot = 1'b1;
                                phase = PH_IDLE;
                            end
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            starts      += int'(want.frame_start);
            captures    += int'(want.slot_valid);
            frames_done += int'(want.last_slot);
            pending_q.push_back(want);
        endfunction

        function void compare(input string name, input int unsigned want, input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_slot(input t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $error("result beat with no byte pending");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            compare("slot_valid", 32'(want.slot_valid), 32'(got.slot_valid));
            compare("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            compare("slot_value", 32'(want.slot_value), 32'(got.slot_value));
            compare("frame_start", 32'(want.frame_start), 32'(got.frame_start));
            compare("last_slot", 32'(want.last_slot), 32'(got.last_slot));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tready = 1'b0;
    wire logic           o_s_tready;
    wire logic           o_m_tvalid;
    wire logic [M_TDATA_W-1:0] o_m_tdata;
    wire logic [M_TUSER_W-1:0] o_m_tuser;
    wire logic           o_m_tlast;

    slot_scoreboard sb = new();
    int  bytes_sent = 0;
    int  addr_settings = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    bit  sink_hold = 1'b0;
    bit  beat_seen = 1'b0;
    int  sink_wait_left = 0;

    dmx512_slot_receiver #(
        .NUM_CHANNELS (SLOTS)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always #5 clk = ~clk;

    // result side: sample at the rising edge
    always @(posedge clk) begin
        t_result got;
        beat_seen = rst_n && o_m_tvalid && m_tready;
        if (beat_seen) begin
            got.slot_valid  = o_m_tuser[0];
            got.slot_index  = o_m_tdata[1:0];
            got.slot_value  = o_m_tdata[9:2];
            got.frame_start = o_m_tuser[1];
            got.last_slot   = o_m_tlast;
            sb.check_slot(got);
        end
    end

    // sink ready, with a random wait drawn after each beat while sink_idle_on is set
    always @(negedge clk) begin
        if (beat_seen) begin
            sink_wait_left = sink_idle_on ? $urandom_range(0, 3) : 0;
        end
        if (sink_hold) begin
            m_tready = 1'b0;
        end else if (sink_wait_left != 0) begin
            m_tready = 1'b0;
            sink_wait_left--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // long sink stall so the skid buffer fills and the input backs up
    initial begin
        wait (bytes_sent >= 300);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (40) @(posedge clk);
        sink_hold <= 1'b0;
        wait (bytes_sent >= 1200);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (60) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic brk);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = brk;
        do @(posedge clk); while (!o_s_tready);
        sb.note_byte(data, brk);
        bytes_sent++;
    endtask

    task automatic park_and_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_start_address(input logic [CNT_W-1:0] addr);
        park_and_drain();
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = addr;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.start_addr = addr;
        addr_settings++;
    endtask

    // one frame: break, start code, slots; some frames are broken or noisy
    task automatic send_frame(input int unsigned addr, input bit clean);
        int unsigned flavour;
        int unsigned n;
        flavour = clean ? 9 : $urandom_range(0, 9);
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        if (flavour == 0) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
        if (flavour == 1) begin
            send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(0, 4)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_byte(8'h00, 1'b0);
            n = addr + SLOTS - 1 + $urandom_range(0, 2);
            if (flavour == 2) begin
                n = $urandom_range(0, addr + SLOTS - 2);
            end
            repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
        if (flavour == 3) begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        int unsigned addr;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset address of 1: idle bytes, short frame, bad start code, breaks mid-frame
        foreach (DIRECTED_BEATS[i]) begin
            send_byte(DIRECTED_BEATS[i][7:0], DIRECTED_BEATS[i][8]);
        end

        set_start_address(10'd512);
        send_frame(512, 1'b1);
        set_start_address(10'd1);
        repeat (4) send_frame(1, 1'b0);

        while (bytes_sent < BYTES_TARGET) begin
            addr = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            set_start_address(CNT_W'(addr));
            repeat ($urandom_range(4, 8)) send_frame(addr, 1'b0);
        end

        park_and_drain();
        repeat (8) @(posedge clk);
        if (sb.pending_q.size() != 0) begin
            $error("%0d result beats never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("covered %0d bytes over %0d start address settings, 1 and 512 among them",
                 bytes_sent, addr_settings);
        $display("%0d zero start codes, %0d channels captured, %0d complete channel sets",
                 sb.starts, sb.captures, sb.frames_done);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
